/* rtl/core/gpr_pkg.sv */
package gpr_pkg;

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  // register byte offsets within the window
  localparam logic [9:0] OFS_MODE      = 10'h000;
  localparam logic [9:0] OFS_OTYPE     = 10'h004;
  localparam logic [9:0] OFS_SPEED     = 10'h008;
  localparam logic [9:0] OFS_PULL      = 10'h00C;
  localparam logic [9:0] OFS_INPUT     = 10'h010;
  localparam logic [9:0] OFS_LATCH     = 10'h014;
  localparam logic [9:0] OFS_SETRST    = 10'h018;
  localparam logic [9:0] OFS_SETRST_HI = 10'h01A;
  localparam logic [9:0] OFS_LOCK      = 10'h01C;
  localparam logic [9:0] OFS_ALT_LO    = 10'h020;
  localparam logic [9:0] OFS_ALT_HI    = 10'h024;

  // two-bit mode field codes that set or clear a pin's direction bit
  localparam logic [1:0] MODE_INPUT  = 2'b00;
  localparam logic [1:0] MODE_OUTPUT = 2'b01;

  localparam int unsigned MAX_PINS = 16;

  // reset values that depend on the port kind
  localparam logic [31:0] KIND0_MODE  = 32'hA800_0000;
  localparam logic [31:0] KIND0_PULL  = 32'h6400_0000;
  localparam logic [31:0] KIND0_SPEED = 32'h0000_0000;
  localparam logic [31:0] KIND1_MODE  = 32'h0000_0280;
  localparam logic [31:0] KIND1_PULL  = 32'h0000_0100;
  localparam logic [31:0] KIND1_SPEED = 32'h0000_00C0;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  reg_offset;
    logic [31:0] write_data;
    logic [3:0]  pin_index;
    logic        pin_level;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        pin_drive_valid;
    logic [3:0]  pin_drive_index;
    logic        pin_drive_level;
  } rsp_t;

endpackage

/* rtl/core/gpr_in_stage.sv */
module gpr_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  gpr_pkg::req_t req,
  input  logic          advance,
  output logic          item_valid,
  output gpr_pkg::req_t item
);

  // the held beat leaves in the same cycle a new one lands
  assign req_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_ready) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
  end

endmodule

/* rtl/core/gpr_regfile.sv */
module gpr_regfile #(
  parameter int PORT_KIND = 0,
  parameter int PIN_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          exec,
  input  gpr_pkg::req_t item,
  output gpr_pkg::rsp_t result
);

  localparam logic [31:0] RST_MODE  = (PORT_KIND == 0) ? gpr_pkg::KIND0_MODE :
                                      (PORT_KIND == 1) ? gpr_pkg::KIND1_MODE : 32'h0;
  localparam logic [31:0] RST_PULL  = (PORT_KIND == 0) ? gpr_pkg::KIND0_PULL :
                                      (PORT_KIND == 1) ? gpr_pkg::KIND1_PULL : 32'h0;
  localparam logic [31:0] RST_SPEED = (PORT_KIND == 0) ? gpr_pkg::KIND0_SPEED :
                                      (PORT_KIND == 1) ? gpr_pkg::KIND1_SPEED : 32'h0;
  localparam logic [4:0]  PIN_LIMIT = 5'(PIN_COUNT);

  logic [31:0] mode_bits, mode_bits_next;
  logic [31:0] output_type_bits, output_type_bits_next;
  logic [31:0] speed_bits, speed_bits_next;
  logic [31:0] pull_bits, pull_bits_next;
  logic [31:0] output_latch, output_latch_next;
  logic [31:0] lock_word, lock_word_next;
  logic [31:0] alt_func_low, alt_func_low_next;
  logic [31:0] alt_func_high, alt_func_high_next;
  logic [15:0] dir_mask, dir_mask_next;

  logic        pin_in_range;
  logic [31:0] read_word;
  logic        is_write;
  logic        is_event;

  assign pin_in_range = {1'b0, item.pin_index} < PIN_LIMIT;
  assign is_write     = exec && (item.command == gpr_pkg::CMD_WRITE);
  assign is_event     = exec && (item.command == gpr_pkg::CMD_EVENT) && pin_in_range;

  always_comb begin
    unique case (item.reg_offset)
      gpr_pkg::OFS_MODE:   read_word = mode_bits;
      gpr_pkg::OFS_OTYPE:  read_word = output_type_bits;
      gpr_pkg::OFS_SPEED:  read_word = speed_bits;
      gpr_pkg::OFS_PULL:   read_word = pull_bits;
      gpr_pkg::OFS_LATCH:  read_word = output_latch;
      gpr_pkg::OFS_LOCK:   read_word = lock_word;
      gpr_pkg::OFS_ALT_LO: read_word = alt_func_low;
      gpr_pkg::OFS_ALT_HI: read_word = alt_func_high;
      default:             read_word = 32'h0;
    endcase
  end

  always_comb begin
    result = '0;
    unique case (item.command)
      gpr_pkg::CMD_READ: begin
        result.read_data = read_word;
      end
      gpr_pkg::CMD_EVENT: begin
        if (pin_in_range) begin
          result.pin_drive_valid = 1'b1;
          result.pin_drive_index = item.pin_index;
          result.pin_drive_level = item.pin_level & dir_mask[item.pin_index];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mode_bits_next        = mode_bits;
    output_type_bits_next = output_type_bits;
    speed_bits_next       = speed_bits;
    pull_bits_next        = pull_bits;
    output_latch_next     = output_latch;
    lock_word_next        = lock_word;
    alt_func_low_next     = alt_func_low;
    alt_func_high_next    = alt_func_high;
    dir_mask_next         = dir_mask;
    if (is_write) begin
      unique case (item.reg_offset)
        gpr_pkg::OFS_MODE: begin
          mode_bits_next = item.write_data;
          for (int p = 0; p < gpr_pkg::MAX_PINS; p++) begin
            if (p < PIN_COUNT) begin
              if (item.write_data[2*p +: 2] == gpr_pkg::MODE_INPUT) begin
                dir_mask_next[p] = 1'b1;
              end else if (item.write_data[2*p +: 2] == gpr_pkg::MODE_OUTPUT) begin
                dir_mask_next[p] = 1'b0;
              end
            end
          end
        end
        gpr_pkg::OFS_OTYPE: output_type_bits_next = item.write_data;
        gpr_pkg::OFS_SPEED: speed_bits_next = item.write_data;
        gpr_pkg::OFS_PULL:  pull_bits_next = item.write_data;
        gpr_pkg::OFS_LATCH: output_latch_next = item.write_data & ~{16'h0, dir_mask};
        // upper half of set/reset: clear bits named in the low half, upper latch bits
        // are masked by the upper data half
        gpr_pkg::OFS_SETRST_HI: begin
          output_latch_next = output_latch & {item.write_data[31:16], ~item.write_data[15:0]};
        end
        // full set/reset: upper latch half always drops, set wins over reset
        gpr_pkg::OFS_SETRST: begin
          output_latch_next = (output_latch & {16'h0, ~item.write_data[31:16]})
                            | {16'h0, item.write_data[15:0]};
        end
        gpr_pkg::OFS_LOCK:   lock_word_next = item.write_data;
        gpr_pkg::OFS_ALT_LO: alt_func_low_next = item.write_data;
        gpr_pkg::OFS_ALT_HI: alt_func_high_next = item.write_data;
        default: begin
        end
      endcase
    end else if (is_event) begin
      output_latch_next = output_latch | (32'(item.pin_level) << item.pin_index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bits        <= RST_MODE;
      output_type_bits <= 32'h0;
      speed_bits       <= RST_SPEED;
      pull_bits        <= RST_PULL;
      output_latch     <= 32'h0;
      lock_word        <= 32'h0;
      alt_func_low     <= 32'h0;
      alt_func_high    <= 32'h0;
      dir_mask         <= 16'h0;
    end else begin
      mode_bits        <= mode_bits_next;
      output_type_bits <= output_type_bits_next;
      speed_bits       <= speed_bits_next;
      pull_bits        <= pull_bits_next;
      output_latch     <= output_latch_next;
      lock_word        <= lock_word_next;
      alt_func_low     <= alt_func_low_next;
      alt_func_high    <= alt_func_high_next;
      dir_mask         <= dir_mask_next;
    end
  end

endmodule

/* rtl/core/gpr_out_stage.sv */
module gpr_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  gpr_pkg::rsp_t result,
  output logic          free,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output gpr_pkg::rsp_t rsp
);

  // slot can take a new beat when empty or being drained this cycle
  assign free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (free) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      rsp <= result;
    end
  end

endmodule

/* rtl/core/gpio_port_registers.sv */
// GPIO port register block: sixteen pins behind a 1 KB register window (mode, output type,
// speed, pull, input, output latch, set/reset, lock, alternate-function low/high). Each beat
// on req is a register read, a register write or a pin level event, and gives exactly one
// beat on rsp. A beat passes an input register, is executed against the register file once
// the output register is free, and its result sits in that output register, which raises
// rsp_valid; one beat is taken every cycle as long as rsp is drained. Reset values of mode,
// speed and pull follow PORT_KIND; PIN_COUNT limits which pins take events and the direction
// updates of mode writes.
module gpio_port_registers #(
  parameter int PORT_KIND = 0,
  parameter int PIN_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  gpr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output gpr_pkg::rsp_t rsp
);

  logic          item_valid;
  gpr_pkg::req_t item;
  logic          advance;
  logic          free;
  gpr_pkg::rsp_t result;

  assign advance = item_valid && free;

  gpr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  gpr_regfile #(
    .PORT_KIND (PORT_KIND),
    .PIN_COUNT (PIN_COUNT)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .exec   (advance),
    .item   (item),
    .result (result)
  );

  gpr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .free      (free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
